// ----- sv/lla_pkg.sv -----
// Shared types and constants for the life-like automaton block.
package lla_pkg;

  localparam int FUNC_W     = 2;
  localparam int COORD_W    = 6;
  localparam int ROW_W      = 64;
  localparam int MASK_W     = 9;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE    = 3'd4;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_ROW  = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic               cell_value;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic               read_value;
    logic [COORD_W-1:0] row_index;
    logic [ROW_W-1:0]   row_bits;
    logic [ROW_W-1:0]   change_mask;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] survive_mask;
    logic [MASK_W-1:0] birth_mask;
    logic              wrap;
  } rule_ctl_t;

endpackage

// ----- sv/lla_ifs.sv -----
// Valid/ready channel interfaces for the input and result words.
interface lla_in_if;
  import lla_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lla_out_if;
  import lla_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- sv/lla_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module lla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/lla_rule.sv -----
// Neighbor count and birth/survive rule for every column of one row.
module lla_rule #(
  parameter int NC = 64
) (
  input  lla_pkg::rule_ctl_t       ctl,
  input  logic [NC-1:0]            up,
  input  logic [NC-1:0]            mid,
  input  logic [NC-1:0]            dn,
  input  logic [NC-1:0]            wm,
  input  logic [$clog2(NC)-1:0]    last_col,
  output logic [NC-1:0]            nb
);
  import lla_pkg::*;

  localparam int CW = $clog2(NC);

  logic [NC-1:0] um;
  logic [NC-1:0] mm;
  logic [NC-1:0] dm;

  assign um = up & wm;
  assign mm = mid & wm;
  assign dm = dn & wm;

  for (genvar c = 0; c < NC; c++) begin : g_col
    logic       ul, ml, dl, ur, mr, dr;
    logic [3:0] cnt;

    if (c == 0) begin : g_left_edge
      assign ul = ctl.wrap & um[last_col];
      assign ml = ctl.wrap & mm[last_col];
      assign dl = ctl.wrap & dm[last_col];
    end else begin : g_left
      assign ul = um[c-1];
      assign ml = mm[c-1];
      assign dl = dm[c-1];
    end

    if (c == NC - 1) begin : g_right_edge
      assign ur = ctl.wrap & um[0];
      assign mr = ctl.wrap & mm[0];
      assign dr = ctl.wrap & dm[0];
    end else begin : g_right
      assign ur = (CW'(c) == last_col) ? (ctl.wrap & um[0]) : um[c+1];
      assign mr = (CW'(c) == last_col) ? (ctl.wrap & mm[0]) : mm[c+1];
      assign dr = (CW'(c) == last_col) ? (ctl.wrap & dm[0]) : dm[c+1];
    end

    assign cnt = 4'(ul) + 4'(um[c]) + 4'(ur) + 4'(ml) + 4'(mr)
               + 4'(dl) + 4'(dm[c]) + 4'(dr);
    assign nb[c] = wm[c] & (mm[c] ? ctl.survive_mask[cnt] : ctl.birth_mask[cnt]);
  end

endmodule

// ----- sv/life_like_automaton_step.sv -----
// Top level of the life-like automaton: board memory, row window and sequencer.
// A cell write reads the row and writes it back with the cell changed if the cell lies in the grid;
// a cell read answers with one read word. An advance makes height + 1 board memory reads; its row
// reports follow one per cycle while the output is not stalled, and the next word is taken after the last.
// Output stalls hold an advance and a read answer. Reset clears the configuration
// to its defaults and marks every board row dead through per-row valid flags.
module life_like_automaton_step #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  lla_in_if.sink                             in_ch,
  lla_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [lla_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lla_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lla_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = $clog2(MAX_ROWS);
  localparam int KW = $clog2(MAX_ROWS + 3);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WR   = 4'b0010,
    ST_RD   = 4'b0100,
    ST_ADV  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [MASK_W-1:0]   survive_r, birth_r;
  logic [SIZE_W-1:0]   gw_r, gh_r;
  logic                wrap_r;

  logic [CW-1:0]       op_col_r;
  logic [AW-1:0]       op_row_r;
  logic                op_val_r;
  logic                op_in_r;
  logic [KW-1:0]       issue_k_r;
  logic [KW-1:0]       load_k_r;
  logic                pend_r;
  logic                win_ok_r;
  logic [AW-1:0]       emit_row_r;
  logic [MAX_COLS-1:0] up_r, mid_r, dn_r, row0_r;
  logic [MAX_ROWS-1:0] vld_r;
  logic                vld_rd_r;
  out_word_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [SIZE_W-1:0]   eff_w, eff_h;
  logic [CW-1:0]       last_col;
  logic [AW-1:0]       last_row;
  logic [MAX_COLS-1:0] wm;
  logic                en, acc, in_grid, issue, shift, emit, done;
  logic                re, we;
  logic [AW-1:0]       raddr, waddr;
  logic [MAX_COLS-1:0] rdata, wdata, rd_word, ld_word, nb, wr_row;
  rule_ctl_t           ctl;

  always_comb begin
    if (gw_r == '0) begin
      eff_w = SIZE_W'(1);
    end else if (gw_r > SIZE_W'(MAX_COLS)) begin
      eff_w = SIZE_W'(MAX_COLS);
    end else begin
      eff_w = gw_r;
    end
    if (gh_r == '0) begin
      eff_h = SIZE_W'(1);
    end else if (gh_r > SIZE_W'(MAX_ROWS)) begin
      eff_h = SIZE_W'(MAX_ROWS);
    end else begin
      eff_h = gh_r;
    end
  end

  assign last_col = CW'(eff_w - SIZE_W'(1));
  assign last_row = AW'(eff_h - SIZE_W'(1));

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_wm
    assign wm[c] = SIZE_W'(c) < eff_w;
  end

  assign ctl.survive_mask = survive_r;
  assign ctl.birth_mask   = birth_r;
  assign ctl.wrap         = wrap_r;

  assign en     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc    = in_ch.valid && in_ch.ready;
  assign in_grid = (SIZE_W'(in_ch.data.cell_col) < eff_w)
                && (SIZE_W'(in_ch.data.cell_row) < eff_h);

  assign issue = (state_r == ST_ADV) && en && (issue_k_r <= KW'(eff_h));
  assign shift = (state_r == ST_ADV) && en
              && (pend_r || (load_k_r == KW'(eff_h) + KW'(1)));
  assign emit  = (state_r == ST_ADV) && en && win_ok_r;
  assign done  = emit && (emit_row_r == last_row);

  always_comb begin
    re    = 1'b0;
    raddr = AW'(in_ch.data.cell_row);
    if (state_r == ST_IDLE) begin
      re = acc && (in_ch.data.func == FUNC_WRITE || in_ch.data.func == FUNC_READ);
    end else if (state_r == ST_ADV) begin
      re    = issue;
      raddr = (issue_k_r == '0) ? last_row : AW'(issue_k_r - KW'(1));
    end
  end

  assign rd_word = vld_rd_r ? rdata : '0;

  always_comb begin
    if (pend_r) begin
      ld_word = (load_k_r == '0 && !wrap_r) ? '0 : rd_word;
    end else begin
      ld_word = wrap_r ? row0_r : '0;
    end
  end

  always_comb begin
    wr_row = rd_word;
    wr_row[op_col_r] = op_val_r;
  end

  assign we    = emit || (state_r == ST_WR);
  assign waddr = emit ? emit_row_r : op_row_r;
  assign wdata = emit ? ((mid_r & ~wm) | nb) : wr_row;

  lla_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_board (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  lla_rule #(
    .NC(MAX_COLS)
  ) u_rule (
    .ctl     (ctl),
    .up      (up_r),
    .mid     (mid_r),
    .dn      (dn_r),
    .wm      (wm),
    .last_col(last_col),
    .nb      (nb)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_ch.data.func)
            FUNC_WRITE:   state_nxt = in_grid ? ST_WR : ST_IDLE;
            FUNC_READ:    state_nxt = ST_RD;
            FUNC_ADVANCE: state_nxt = ST_ADV;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WR:   state_nxt = ST_IDLE;
      ST_RD:   state_nxt = en ? ST_IDLE : ST_RD;
      ST_ADV:  state_nxt = done ? ST_IDLE : ST_ADV;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (emit) begin
      out_nxt.kind        = KIND_ROW;
      out_nxt.read_value  = 1'b0;
      out_nxt.row_index   = COORD_W'(emit_row_r);
      out_nxt.row_bits    = ROW_W'(nb);
      out_nxt.change_mask = ROW_W'((nb ^ mid_r) & wm);
      out_nxt.last        = done;
      out_valid_nxt       = 1'b1;
    end else if (state_r == ST_RD && en) begin
      out_nxt.kind        = KIND_READ;
      out_nxt.read_value  = op_in_r & rd_word[op_col_r];
      out_nxt.row_index   = '0;
      out_nxt.row_bits    = '0;
      out_nxt.change_mask = '0;
      out_nxt.last        = 1'b0;
      out_valid_nxt       = 1'b1;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      survive_r   <= MASK_W'(12);
      birth_r     <= MASK_W'(8);
      gw_r        <= SIZE_W'(64);
      gh_r        <= SIZE_W'(64);
      wrap_r      <= 1'b0;
      issue_k_r   <= '0;
      load_k_r    <= '0;
      pend_r      <= 1'b0;
      win_ok_r    <= 1'b0;
      emit_row_r  <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SURVIVE: survive_r <= cfg_wdata[MASK_W-1:0];
          CFG_BIRTH:   birth_r   <= cfg_wdata[MASK_W-1:0];
          CFG_WIDTH:   gw_r      <= cfg_wdata[SIZE_W-1:0];
          CFG_HEIGHT:  gh_r      <= cfg_wdata[SIZE_W-1:0];
          CFG_EDGE:    wrap_r    <= cfg_wdata[0];
          default:     ;
        endcase
      end
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (acc) begin
        issue_k_r  <= '0;
        load_k_r   <= '0;
        pend_r     <= 1'b0;
        win_ok_r   <= 1'b0;
        emit_row_r <= '0;
      end else if (state_r == ST_ADV && en) begin
        pend_r   <= issue;
        win_ok_r <= shift && (load_k_r >= KW'(2));
        if (issue) begin
          issue_k_r <= issue_k_r + KW'(1);
        end
        if (shift) begin
          load_k_r <= load_k_r + KW'(1);
        end
        if (emit) begin
          emit_row_r <= emit_row_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (re) begin
      vld_rd_r <= vld_r[raddr];
    end
    if (acc) begin
      op_col_r <= CW'(in_ch.data.cell_col);
      op_row_r <= AW'(in_ch.data.cell_row);
      op_val_r <= in_ch.data.cell_value;
      op_in_r  <= in_grid;
    end
    if (shift) begin
      up_r  <= mid_r;
      mid_r <= dn_r;
      dn_r  <= ld_word;
      if (load_k_r == KW'(1)) begin
        row0_r <= ld_word;
      end
    end
  end

endmodule
